### hdl/hrm_pkg.sv
// shared types, constants, exp table and helpers for the heisenberg ring metropolis block
package hrm_pkg;

  localparam int MAX_SITES_DEF  = 64;
  localparam int COMP_COUNT_DEF = 3;
  localparam int NCOMP          = 3;
  localparam int COMP_W         = 16;
  localparam int SITE_W         = 6;
  localparam int LEN_W          = 7;
  localparam int BETA_W         = 16;
  localparam int WARM_W         = 16;
  localparam int SWEEP_W        = 32;
  localparam int UNIF_W         = 16;
  localparam int KIND_W         = 2;
  localparam int SUM_W          = 36;
  localparam int MAG_W          = 22;
  localparam int ACC_W          = 40;
  localparam int OPND_W         = COMP_W + 1;
  localparam int PROD_W         = 2 * OPND_W;
  localparam int DELTA_W        = SUM_W + BETA_W + 1;
  localparam int DELTA_FRAC     = 40;
  localparam int S_TDATA_W      = 72;
  localparam int M_TDATA_W      = 152;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int UNIT_Q14       = 16384;

  localparam int EXP_DEPTH = 256;
  localparam int EXP_SPAN  = 16;
  localparam int EXP_W     = 17;
  localparam int IDX_W     = $clog2(EXP_DEPTH);

  typedef logic [NCOMP*COMP_W-1:0] spin_t;
  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [EXP_W-1:0] exp_tab_t [EXP_DEPTH];

  typedef enum logic [KIND_W-1:0] {
    KIND_PROPOSE = 2'd0,
    KIND_MEASURE = 2'd1,
    KIND_WRITE   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA = 2'd0,
    CFG_LEN  = 2'd1,
    CFG_WARM = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_WRITE,
    ST_P_RD1, ST_P_RD2, ST_P_LOAD, ST_P_MUL, ST_P_DRAIN, ST_P_BETA, ST_P_NEG,
    ST_P_DEC, ST_P_OUT,
    ST_M_CNT, ST_M_RD, ST_M_LOAD, ST_M_MUL, ST_M_DRAIN, ST_M_FIN, ST_M_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_WRITE, OP_P_RD1, OP_P_RD2, OP_P_LOAD, OP_MUL,
    OP_BETA, OP_NEG, OP_DEC, OP_P_OUT, OP_M_CNT, OP_M_RD, OP_M_LOAD,
    OP_M_FIN, OP_M_EMIT
  } op_t;

  typedef struct packed {
    kind_t kind;
    logic  site_ok;
    logic  k_last;
    logic  i_last;
    logic  d_last;
    logic  pre;
    logic  emit_ok;
    logic  out_free;
  } status_t;

  // exp(-k*span/depth) in Q1.16, ratio from a truncated taylor series in Q0.32
  function automatic exp_tab_t exp_table_build();
    exp_tab_t t;
    longint unsigned term;
    longint unsigned r;
    longint unsigned cur;
    longint sum;
    term = 64'd1 << 32;
    sum  = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = term * 64'(EXP_SPAN) / 64'(EXP_DEPTH * n);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    r   = longint'(sum);
    cur = 64'd1 << 32;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      t[k] = EXP_W'((cur + (64'd1 << 15)) >> 16);
      cur  = (cur * r + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TABLE = exp_table_build();

  function automatic comp_t comp_of(spin_t s, logic [1:0] k);
    return comp_t'(s[k*COMP_W +: COMP_W]);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [ACC_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v[ACC_W-1:SUM_W-1] == '0 || v[ACC_W-1:SUM_W-1] == '1) r = v[SUM_W-1:0];
    else if (v[ACC_W-1]) r = {1'b1, {(SUM_W-1){1'b0}}};
    else r = {1'b0, {(SUM_W-1){1'b1}}};
    return r;
  endfunction

endpackage

### hdl/hrm_ctrl.sv
// sequencing state machine for proposals, spin writes and measurement passes
module hrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  hrm_pkg::status_t  status,
  output logic              s_tready,
  output hrm_pkg::op_t      op
);

  hrm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= hrm_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      hrm_pkg::ST_IDLE:     if (s_tvalid) state_next = hrm_pkg::ST_DISPATCH;
      hrm_pkg::ST_DISPATCH: begin
        case (status.kind)
          hrm_pkg::KIND_PROPOSE:
            state_next = status.site_ok ? hrm_pkg::ST_P_RD1 : hrm_pkg::ST_P_OUT;
          hrm_pkg::KIND_MEASURE: state_next = hrm_pkg::ST_M_CNT;
          hrm_pkg::KIND_WRITE:   state_next = hrm_pkg::ST_WRITE;
          default:               state_next = hrm_pkg::ST_IDLE;
        endcase
      end
      hrm_pkg::ST_WRITE:   state_next = hrm_pkg::ST_IDLE;
      hrm_pkg::ST_P_RD1:   state_next = hrm_pkg::ST_P_RD2;
      hrm_pkg::ST_P_RD2:   state_next = hrm_pkg::ST_P_LOAD;
      hrm_pkg::ST_P_LOAD:  state_next = hrm_pkg::ST_P_MUL;
      hrm_pkg::ST_P_MUL:   if (status.k_last) state_next = hrm_pkg::ST_P_DRAIN;
      hrm_pkg::ST_P_DRAIN: state_next = hrm_pkg::ST_P_BETA;
      hrm_pkg::ST_P_BETA:  state_next = hrm_pkg::ST_P_NEG;
      hrm_pkg::ST_P_NEG:   state_next = hrm_pkg::ST_P_DEC;
      hrm_pkg::ST_P_DEC:   state_next = hrm_pkg::ST_P_OUT;
      hrm_pkg::ST_P_OUT:   if (status.out_free) state_next = hrm_pkg::ST_IDLE;
      hrm_pkg::ST_M_CNT:
        state_next = status.emit_ok ? hrm_pkg::ST_M_RD : hrm_pkg::ST_IDLE;
      hrm_pkg::ST_M_RD:    state_next = hrm_pkg::ST_M_LOAD;
      hrm_pkg::ST_M_LOAD:  state_next = hrm_pkg::ST_M_MUL;
      hrm_pkg::ST_M_MUL: begin
        if (status.k_last)
          state_next = status.i_last ? hrm_pkg::ST_M_DRAIN : hrm_pkg::ST_M_RD;
      end
      hrm_pkg::ST_M_DRAIN: state_next = hrm_pkg::ST_M_FIN;
      hrm_pkg::ST_M_FIN:
        state_next = status.pre ? hrm_pkg::ST_M_RD : hrm_pkg::ST_M_EMIT;
      hrm_pkg::ST_M_EMIT: begin
        if (status.out_free)
          state_next = status.d_last ? hrm_pkg::ST_IDLE : hrm_pkg::ST_M_RD;
      end
      default: state_next = hrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op       = hrm_pkg::OP_NONE;
    s_tready = 1'b0;
    case (state)
      hrm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) op = hrm_pkg::OP_CAPTURE;
      end
      hrm_pkg::ST_WRITE:  op = hrm_pkg::OP_WRITE;
      hrm_pkg::ST_P_RD1:  op = hrm_pkg::OP_P_RD1;
      hrm_pkg::ST_P_RD2:  op = hrm_pkg::OP_P_RD2;
      hrm_pkg::ST_P_LOAD: op = hrm_pkg::OP_P_LOAD;
      hrm_pkg::ST_P_MUL:  op = hrm_pkg::OP_MUL;
      hrm_pkg::ST_P_BETA: op = hrm_pkg::OP_BETA;
      hrm_pkg::ST_P_NEG:  op = hrm_pkg::OP_NEG;
      hrm_pkg::ST_P_DEC:  op = hrm_pkg::OP_DEC;
      hrm_pkg::ST_P_OUT:  if (status.out_free) op = hrm_pkg::OP_P_OUT;
      hrm_pkg::ST_M_CNT:  op = hrm_pkg::OP_M_CNT;
      hrm_pkg::ST_M_RD:   op = hrm_pkg::OP_M_RD;
      hrm_pkg::ST_M_LOAD: op = hrm_pkg::OP_M_LOAD;
      hrm_pkg::ST_M_MUL:  op = hrm_pkg::OP_MUL;
      hrm_pkg::ST_M_FIN:  op = hrm_pkg::OP_M_FIN;
      hrm_pkg::ST_M_EMIT: if (status.out_free) op = hrm_pkg::OP_M_EMIT;
      default:            op = hrm_pkg::OP_NONE;
    endcase
  end

endmodule

### hdl/hrm_dp.sv
// datapath: config registers, spin memory, shared multiplier, accumulators, output register
module hrm_dp #(
  parameter int MAX_SITES  = hrm_pkg::MAX_SITES_DEF,
  parameter int COMP_COUNT = hrm_pkg::COMP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hrm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hrm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [hrm_pkg::S_TDATA_W-1:0]       s_tdata,
  input  logic [hrm_pkg::KIND_W-1:0]          s_tuser,
  input  hrm_pkg::op_t                        op,
  output hrm_pkg::status_t                    status,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hrm_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                m_tlast
);

  localparam int AW = $clog2(MAX_SITES);
  localparam int LW = hrm_pkg::LEN_W;
  localparam hrm_pkg::spin_t SPIN_RESET = hrm_pkg::spin_t'(hrm_pkg::UNIT_Q14);

  // configuration
  logic [hrm_pkg::BETA_W-1:0]  beta_q;
  logic [LW-1:0]               len_raw_q;
  logic [hrm_pkg::WARM_W-1:0]  warm_q;
  logic [LW-1:0]               len;

  // captured item
  hrm_pkg::kind_t              kind_q;
  logic [hrm_pkg::SITE_W-1:0]  site_q;
  hrm_pkg::spin_t              nv_q;
  logic [hrm_pkg::UNIF_W-1:0]  unif_q;

  // spin store
  hrm_pkg::spin_t              mem [MAX_SITES];
  logic [MAX_SITES-1:0]        vld;
  hrm_pkg::spin_t              rda, rdb;
  logic                        rva, rvb;
  hrm_pkg::spin_t              sa, sb;
  logic [AW-1:0]               addr_a, addr_b, site_a, left_a, right_a, j_a;
  logic                        rd_en, wr_en;
  logic [LW-1:0]               site_p1, j_sum, j_wrap;

  // proposal arithmetic
  hrm_pkg::spin_t                      old_q, lft_q;
  logic signed [hrm_pkg::OPND_W-1:0]   df_q [hrm_pkg::NCOMP];
  logic signed [hrm_pkg::OPND_W-1:0]   nb_q [hrm_pkg::NCOMP];
  logic [1:0]                          k_q;
  logic signed [hrm_pkg::OPND_W-1:0]   mul_a, mul_b;
  logic signed [hrm_pkg::PROD_W-1:0]   prod_q;
  logic                                prod_vld;
  logic signed [hrm_pkg::ACC_W-1:0]    acc_q;
  logic signed [hrm_pkg::SUM_W-1:0]    dot_s;
  logic signed [hrm_pkg::BETA_W:0]     beta_s;
  logic signed [hrm_pkg::DELTA_W-1:0]  delta_q;
  logic [hrm_pkg::DELTA_W-1:0]         ndel_q;
  logic                                neg_q;
  logic                                accept, acc_flag_q;
  logic [hrm_pkg::IDX_W-1:0]           exp_idx;

  // measurement
  logic [hrm_pkg::SWEEP_W-1:0]         sweep_q, sweep_inc;
  logic [AW-1:0]                       i_q, d_q, d_eff;
  logic                                pre_q, pair_last_q;
  logic signed [hrm_pkg::SUM_W-1:0]    energy_q;
  logic signed [hrm_pkg::MAG_W-1:0]    mag_q [hrm_pkg::NCOMP];
  logic                                meas;

  always_comb begin
    if (len_raw_q < LW'(2)) len = LW'(2);
    else if (len_raw_q > LW'(MAX_SITES)) len = LW'(MAX_SITES);
    else len = len_raw_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_q    <= hrm_pkg::BETA_W'(256);
      len_raw_q <= LW'(64);
      warm_q    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hrm_pkg::CFG_BETA: beta_q    <= cfg_data;
        hrm_pkg::CFG_LEN:  len_raw_q <= cfg_data[LW-1:0];
        hrm_pkg::CFG_WARM: warm_q    <= cfg_data;
        default: ;
      endcase
    end
  end

  // addresses around the ring
  assign site_a  = site_q[AW-1:0];
  assign left_a  = (site_a == '0) ? AW'(len - LW'(1)) : site_a - AW'(1);
  assign site_p1 = LW'(site_q) + LW'(1);
  assign right_a = (site_p1 < len) ? AW'(site_p1) : '0;
  assign d_eff   = pre_q ? AW'(1) : d_q;
  assign j_sum   = LW'(i_q) + LW'(d_eff);
  assign j_wrap  = (j_sum >= len) ? j_sum - len : j_sum;
  assign j_a     = AW'(j_wrap);

  always_comb begin
    addr_a = i_q;
    addr_b = j_a;
    rd_en  = 1'b0;
    case (op)
      hrm_pkg::OP_P_RD1: begin
        addr_a = site_a;
        addr_b = left_a;
        rd_en  = 1'b1;
      end
      hrm_pkg::OP_P_RD2: begin
        addr_a = right_a;
        addr_b = left_a;
        rd_en  = 1'b1;
      end
      hrm_pkg::OP_M_RD: rd_en = 1'b1;
      default: ;
    endcase
  end

  assign wr_en = (op == hrm_pkg::OP_WRITE && status.site_ok) ||
                 (op == hrm_pkg::OP_DEC && accept);

  always_ff @(posedge clk) begin
    if (wr_en) mem[site_a] <= nv_q;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rda <= mem[addr_a];
      rdb <= mem[addr_b];
      rva <= vld[addr_a];
      rvb <= vld[addr_b];
    end
  end

  // a site never written holds the unit vector along the first axis
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (wr_en) vld[site_a] <= 1'b1;
  end

  assign sa = rva ? rda : SPIN_RESET;
  assign sb = rvb ? rdb : SPIN_RESET;

  always_ff @(posedge clk) begin
    if (op == hrm_pkg::OP_CAPTURE) begin
      kind_q <= hrm_pkg::kind_t'(s_tuser);
      site_q <= s_tdata[hrm_pkg::SITE_W-1:0];
      for (int k = 0; k < hrm_pkg::NCOMP; k++)
        nv_q[k*hrm_pkg::COMP_W +: hrm_pkg::COMP_W] <= (k < COMP_COUNT) ?
          s_tdata[hrm_pkg::SITE_W + k*hrm_pkg::COMP_W +: hrm_pkg::COMP_W] : '0;
      unif_q <= s_tdata[hrm_pkg::SITE_W + hrm_pkg::NCOMP*hrm_pkg::COMP_W +: hrm_pkg::UNIF_W];
    end
  end

  assign meas = (kind_q == hrm_pkg::KIND_MEASURE);

  always_comb begin
    if (meas) begin
      mul_a = hrm_pkg::OPND_W'(hrm_pkg::comp_of(sa, k_q));
      mul_b = hrm_pkg::OPND_W'(hrm_pkg::comp_of(sb, k_q));
    end else begin
      mul_a = df_q[k_q];
      mul_b = nb_q[k_q];
    end
  end

  always_ff @(posedge clk) begin
    if (op == hrm_pkg::OP_P_RD2) begin
      old_q <= sa;
      lft_q <= sb;
    end
    if (op == hrm_pkg::OP_P_LOAD) begin
      for (int k = 0; k < hrm_pkg::NCOMP; k++) begin
        df_q[k] <= hrm_pkg::OPND_W'(hrm_pkg::comp_of(nv_q, 2'(k))) -
                   hrm_pkg::OPND_W'(hrm_pkg::comp_of(old_q, 2'(k)));
        nb_q[k] <= hrm_pkg::OPND_W'(hrm_pkg::comp_of(sa, 2'(k))) +
                   hrm_pkg::OPND_W'(hrm_pkg::comp_of(lft_q, 2'(k)));
      end
    end
    if (op == hrm_pkg::OP_MUL) prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_q      <= '0;
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (op == hrm_pkg::OP_MUL);
      if (op == hrm_pkg::OP_P_LOAD || op == hrm_pkg::OP_M_LOAD) k_q <= '0;
      else if (op == hrm_pkg::OP_MUL) k_q <= status.k_last ? 2'd0 : k_q + 2'd1;
    end
  end

  // products are registered before they are added; a correlation sum is kept until emitted
  always_ff @(posedge clk) begin
    if (op == hrm_pkg::OP_P_LOAD || op == hrm_pkg::OP_M_CNT ||
        (op == hrm_pkg::OP_M_FIN && pre_q) || op == hrm_pkg::OP_M_EMIT)
      acc_q <= '0;
    else if (prod_vld)
      acc_q <= acc_q + hrm_pkg::ACC_W'(prod_q);
  end

  assign dot_s  = acc_q[hrm_pkg::SUM_W-1:0];
  assign beta_s = {1'b0, beta_q};

  assign exp_idx = ndel_q[hrm_pkg::DELTA_FRAC-1 -: hrm_pkg::IDX_W];
  assign accept  = !neg_q ||
                   (ndel_q[hrm_pkg::DELTA_W-1:hrm_pkg::DELTA_FRAC] == '0 &&
                    {1'b0, unif_q} < hrm_pkg::EXP_TABLE[exp_idx]);

  always_ff @(posedge clk) begin
    if (op == hrm_pkg::OP_BETA)
      delta_q <= hrm_pkg::DELTA_W'(dot_s) * hrm_pkg::DELTA_W'(beta_s);
    if (op == hrm_pkg::OP_NEG) begin
      neg_q  <= delta_q[hrm_pkg::DELTA_W-1];
      ndel_q <= -delta_q;
    end
    if (op == hrm_pkg::OP_CAPTURE) acc_flag_q <= 1'b0;
    else if (op == hrm_pkg::OP_DEC) acc_flag_q <= accept;
  end

  // measurement walk: a first pass at distance one gives energy and magnetization
  assign sweep_inc = (sweep_q == '1) ? sweep_q : sweep_q + hrm_pkg::SWEEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) sweep_q <= '0;
    else if (op == hrm_pkg::OP_M_CNT) sweep_q <= sweep_inc;
  end

  always_ff @(posedge clk) begin
    case (op)
      hrm_pkg::OP_M_CNT: begin
        i_q   <= '0;
        d_q   <= '0;
        pre_q <= 1'b1;
        for (int k = 0; k < hrm_pkg::NCOMP; k++) mag_q[k] <= '0;
      end
      hrm_pkg::OP_M_LOAD: begin
        i_q         <= i_q + AW'(1);
        pair_last_q <= (LW'(i_q) == len - LW'(1));
        if (pre_q)
          for (int k = 0; k < hrm_pkg::NCOMP; k++)
            mag_q[k] <= mag_q[k] + hrm_pkg::MAG_W'(hrm_pkg::comp_of(sa, 2'(k)));
      end
      hrm_pkg::OP_M_FIN: begin
        if (pre_q) begin
          energy_q <= hrm_pkg::sat_sum(-acc_q);
          pre_q    <= 1'b0;
          i_q      <= '0;
        end
      end
      hrm_pkg::OP_M_EMIT: begin
        d_q <= d_q + AW'(1);
        i_q <= '0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (op == hrm_pkg::OP_P_OUT || op == hrm_pkg::OP_M_EMIT) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (op == hrm_pkg::OP_P_OUT) begin
      m_tdata <= hrm_pkg::M_TDATA_W'(acc_flag_q);
      m_tlast <= 1'b1;
    end else if (op == hrm_pkg::OP_M_EMIT) begin
      m_tdata <= hrm_pkg::M_TDATA_W'({hrm_pkg::sat_sum(acc_q),
                                      hrm_pkg::SITE_W'(d_q),
                                      mag_q[2], mag_q[1], mag_q[0],
                                      energy_q, 1'b0});
      m_tlast <= status.d_last;
    end
  end

  always_comb begin
    status.kind     = kind_q;
    status.site_ok  = (LW'(site_q) < len);
    status.k_last   = (k_q == 2'(hrm_pkg::NCOMP - 1));
    status.i_last   = pair_last_q;
    status.d_last   = (LW'(d_q) == len - LW'(1));
    status.pre      = pre_q;
    status.emit_ok  = (sweep_inc > hrm_pkg::SWEEP_W'(warm_q));
    status.out_free = !m_tvalid || m_tready;
  end

endmodule

### hdl/heisenberg_ring_metropolis.sv
// top level of the metropolis engine for a periodic classical heisenberg chain
// One item at a time. A spin write and a measurement still in warm-up give no result;
// a proposal, also one for a site outside the ring, may wait for the output register,
// and an emitting measurement gives L results for ring length L and may wait for the
// output register at each of them.
// The work is paced by the single 17x17 multiplier, which forms one component
// product per cycle, and by the spin memory, which gives two sites per read.
// The spin store comes out of reset holding the unit vector along the first axis
// at every site, through per-site valid bits; no clearing pass is needed.
module heisenberg_ring_metropolis #(
  parameter int MAX_SITES  = hrm_pkg::MAX_SITES_DEF,
  parameter int COMP_COUNT = hrm_pkg::COMP_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // site, comp_a, comp_b, comp_c, uniform, zero pad
  input  logic [hrm_pkg::S_TDATA_W-1:0]  s_tdata,
  // kind
  input  logic [hrm_pkg::KIND_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // accepted, energy_sum, mag_a, mag_b, mag_c, distance, corr_sum, zero pad
  output logic [hrm_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                           m_tlast
);

  hrm_pkg::op_t     op;
  hrm_pkg::status_t status;

  hrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .s_tready (s_tready),
    .op       (op)
  );

  hrm_dp #(
    .MAX_SITES  (MAX_SITES),
    .COMP_COUNT (COMP_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .op        (op),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  a_accept_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tlast)
    else $error("accepted proposal result without last");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (op == hrm_pkg::OP_P_OUT || op == hrm_pkg::OP_M_EMIT) |-> (!m_tvalid || m_tready))
    else $error("output register overwritten before transfer");
`endif

endmodule

### verif/tb_heisenberg_ring_metropolis.sv
// self-checking testbench for the heisenberg ring metropolis engine
module tb_heisenberg_ring_metropolis;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hrm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam longint SUM_MAX = 64'sd34359738367;
  localparam longint SUM_MIN = -64'sd34359738368;

  typedef struct {
    logic [hrm_pkg::KIND_W-1:0] kind;
    logic [5:0]        site;
    logic [15:0]       ca, cb, cc;
    logic [15:0]       uniform;
  } spin_item_t;

  typedef struct {
    logic        acc;
    logic [35:0] energy;
    logic [21:0] ma, mb, mc;
    logic [5:0]  corr_dist;
    logic [35:0] corr;
    logic        last;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [hrm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hrm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [hrm_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [hrm_pkg::KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [hrm_pkg::M_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  heisenberg_ring_metropolis dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  // predictor state
  int          ring_spin[64][3];
  int unsigned beta_q88 = 256;
  int unsigned len_raw = 64;
  int unsigned warm_sweeps = 0;
  int unsigned sweeps = 0;
  int unsigned exp_lut[256];
  ring_result_t pending_q[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit calm = 1'b0;

  function automatic void build_exp_lut();
    longint unsigned term, ratio, cur;
    longint acc;
    term = 64'd1 << 32;
    acc = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = term * 64'd16 / (64'd256 * n);
      if (n % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    ratio = longint'(acc);
    cur = 64'd1 << 32;
    for (int k = 0; k < 256; k++) begin
      exp_lut[k] = int'((cur + (64'd1 << 15)) >> 16);
      cur = (cur * ratio + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic longint clamp36(longint v);
    return v > SUM_MAX ? SUM_MAX : (v < SUM_MIN ? SUM_MIN : v);
  endfunction

  function automatic int unsigned ring_len();
    return len_raw < 2 ? 2 : (len_raw > 64 ? 64 : len_raw);
  endfunction

  function automatic longint spin_dot(int i, int j);
    longint s = 0;
    for (int k = 0; k < 3; k++) s += longint'(ring_spin[i][k]) * ring_spin[j][k];
    return s;
  endfunction

  task automatic predict(spin_item_t it);
    int unsigned len, r, l;
    int nv[3];
    int df, nb;
    longint delta, energy, c;
    longint mag[3];
    longint unsigned idx;
    ring_result_t e;
    len = ring_len();
    nv[0] = int'($signed(it.ca));
    nv[1] = int'($signed(it.cb));
    nv[2] = int'($signed(it.cc));
    e = '{default: '0};
    case (it.kind)
      hrm_pkg::KIND_WRITE: begin
        if (it.site < len) for (int k = 0; k < 3; k++) ring_spin[it.site][k] = nv[k];
      end
      hrm_pkg::KIND_PROPOSE: begin
        if (it.site < len) begin
          r = (it.site + 1 < len) ? it.site + 1 : 0;
          l = (it.site == 0) ? len - 1 : it.site - 1;
          delta = 0;
          for (int k = 0; k < 3; k++) begin
            df = nv[k] - ring_spin[it.site][k];
            nb = ring_spin[r][k] + ring_spin[l][k];
            delta += longint'(df) * nb;
          end
          delta *= longint'(beta_q88);
          if (delta >= 0) e.acc = 1'b1;
          else begin
            idx = (longint'(-delta) * 256) >> 40;
            if (idx < 256 && it.uniform < exp_lut[idx]) e.acc = 1'b1;
          end
          if (e.acc) for (int k = 0; k < 3; k++) ring_spin[it.site][k] = nv[k];
        end
        e.last = 1'b1;
        pending_q.insert(pending_q.size(), e);
      end
      hrm_pkg::KIND_MEASURE: begin
        if (sweeps != 32'hFFFF_FFFF) sweeps++;
        if (sweeps > warm_sweeps) begin
          energy = 0;
          mag = '{0, 0, 0};
          for (int i = 0; i < len; i++) begin
            for (int k = 0; k < 3; k++) mag[k] += ring_spin[i][k];
            energy -= spin_dot(i, (i + 1 < len) ? i + 1 : 0);
          end
          energy = clamp36(energy);
          for (int d = 0; d < len; d++) begin
            c = 0;
            for (int i = 0; i < len; i++) c += spin_dot(i, (i + d) % len);
            e.acc = 1'b0;
            e.energy = energy[35:0];
            e.ma = mag[0][21:0];
            e.mb = mag[1][21:0];
            e.mc = mag[2][21:0];
            e.corr_dist = d[5:0];
            c = clamp36(c);
            e.corr = c[35:0];
            e.last = (d + 1 == len);
            pending_q.insert(pending_q.size(), e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    ring_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata[63:0], 64'd0);
      end else begin
        w = pending_q.pop_front();
        if (m_tdata[0] !== w.acc) report_mismatch("accepted", m_tdata[0], w.acc);
        if (m_tdata[36:1] !== w.energy) report_mismatch("energy_sum", m_tdata[36:1], w.energy);
        if (m_tdata[58:37] !== w.ma) report_mismatch("mag_a", m_tdata[58:37], w.ma);
        if (m_tdata[80:59] !== w.mb) report_mismatch("mag_b", m_tdata[80:59], w.mb);
        if (m_tdata[102:81] !== w.mc) report_mismatch("mag_c", m_tdata[102:81], w.mc);
        if (m_tdata[108:103] !== w.corr_dist)
          report_mismatch("distance", m_tdata[108:103], w.corr_dist);
        if (m_tdata[144:109] !== w.corr) report_mismatch("corr_sum", m_tdata[144:109], w.corr);
        if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
      end
      results_seen++;
    end
  end

  // receiver back-pressure in bursts
  initial begin
    int stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) m_tready <= 1'b1;
      else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send_item(spin_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {2'b00, it.uniform, it.cc, it.cb, it.ca, it.site};
    do @(posedge clk); while (!s_tready);
    predict(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] kind, int site, int a, int b, int c, int u);
    spin_item_t it;
    it.kind = kind;
    it.site = site[5:0];
    it.ca = a[15:0];
    it.cb = b[15:0];
    it.cc = c[15:0];
    it.uniform = u[15:0];
    send_item(it);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(hrm_pkg::cfg_idx_t idx, int unsigned value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    case (idx)
      hrm_pkg::CFG_BETA: beta_q88 = value & 16'hFFFF;
      hrm_pkg::CFG_LEN:  len_raw = value & 7'h7F;
      hrm_pkg::CFG_WARM: warm_sweeps = value & 16'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_comp();
    if ($urandom_range(0, 6) == 0) return int'($urandom_range(0, 65535));
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic test_reset_state();
    // full ring of unit spins straight out of reset
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
  endtask

  task automatic test_directed_ops();
    write_reg(hrm_pkg::CFG_LEN, 4);
    send_fields(hrm_pkg::KIND_WRITE, 0, 16384, 0, 0, 0);
    send_fields(hrm_pkg::KIND_WRITE, 1, -16384, 0, 0, 0);
    send_fields(hrm_pkg::KIND_WRITE, 2, 0, 16384, 0, 0);
    send_fields(hrm_pkg::KIND_WRITE, 3, 16'h7FFF, 16'h8000, -16384, 16'hFFFF);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
    send_fields(hrm_pkg::KIND_WRITE, 3, 0, 0, -16384, 0);
    send_fields(hrm_pkg::KIND_PROPOSE, 1, 16384, 0, 0, 0);
    send_fields(hrm_pkg::KIND_PROPOSE, 0, -16384, 0, 0, 0);
    send_fields(hrm_pkg::KIND_PROPOSE, 2, 0, -16384, 0, 65535);
    send_fields(hrm_pkg::KIND_PROPOSE, 3, 0, 0, 16384, 0);
    // site outside the ring
    send_fields(hrm_pkg::KIND_PROPOSE, 5, 0, 16384, 0, 0);
    send_fields(hrm_pkg::KIND_WRITE, 63, 0, 0, 16384, 0);
    send_fields(KIND_UNUSED, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(hrm_pkg::KIND_MEASURE, 63, 0, 0, 0, 0);
    write_reg(hrm_pkg::CFG_BETA, 0);
    send_fields(hrm_pkg::KIND_PROPOSE, 0, 0, 0, 16384, 65535);
    write_reg(hrm_pkg::CFG_BETA, 65535);
    send_fields(hrm_pkg::KIND_PROPOSE, 0, -16384, 0, 0, 0);
    send_fields(hrm_pkg::KIND_PROPOSE, 3, 0, 0, 16384, 12);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
    write_reg(hrm_pkg::CFG_BETA, 256);
  endtask

  task automatic test_warmup();
    write_reg(hrm_pkg::CFG_WARM, sweeps + 3);
    repeat (4) send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
    write_reg(hrm_pkg::CFG_WARM, 65535);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
    write_reg(hrm_pkg::CFG_WARM, 0);
  endtask

  task automatic test_ring_length_limits();
    write_reg(hrm_pkg::CFG_LEN, 0);
    send_fields(hrm_pkg::KIND_PROPOSE, 1, 0, 16384, 0, 0);
    send_fields(hrm_pkg::KIND_PROPOSE, 2, 0, 16384, 0, 0);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
    write_reg(hrm_pkg::CFG_LEN, 1);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
    write_reg(hrm_pkg::CFG_LEN, 127);
    send_fields(hrm_pkg::KIND_PROPOSE, 63, 0, 0, -16384, 0);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
  endtask

  task automatic test_sum_saturation();
    write_reg(hrm_pkg::CFG_LEN, 16);
    // aligned extreme spins drive energy low and correlation high
    for (int i = 0; i < 16; i++)
      send_fields(hrm_pkg::KIND_WRITE, i, -32768, -32768, -32768, 0);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
    // alternating extremes drive energy high and odd distances low
    for (int i = 0; i < 16; i += 2)
      send_fields(hrm_pkg::KIND_WRITE, i, 32767, 32767, 32767, 0);
    send_fields(hrm_pkg::KIND_MEASURE, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_walk(int phases, int per_phase);
    int unsigned len, pick;
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 1) calm = 1'b1;
      pick = $urandom_range(0, 9);
      write_reg(hrm_pkg::CFG_LEN, pick == 0 ? $urandom_range(2, 16) : $urandom_range(2, 8));
      write_reg(hrm_pkg::CFG_BETA, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                             : $urandom_range(0, 1024));
      write_reg(hrm_pkg::CFG_WARM, $urandom_range(0, 1) ? 0 : sweeps + $urandom_range(0, 2));
      len = ring_len();
      for (int n = 0; n < per_phase; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 11)
          send_fields(hrm_pkg::KIND_PROPOSE,
                      $urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
                                                : $urandom_range(0, len - 1),
                      rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 65535));
        else if (pick < 16)
          send_fields(hrm_pkg::KIND_WRITE,
                      $urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
                                                : $urandom_range(0, len - 1),
                      rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 65535));
        else if (pick < 19)
          send_fields(hrm_pkg::KIND_MEASURE, $urandom_range(0, 63), rand_comp(), rand_comp(),
                      rand_comp(), $urandom_range(0, 65535));
        else
          send_fields(KIND_UNUSED, $urandom_range(0, 63), rand_comp(), rand_comp(),
                      rand_comp(), $urandom_range(0, 65535));
      end
    end
  endtask

  initial begin
    build_exp_lut();
    for (int i = 0; i < 64; i++) ring_spin[i] = '{16384, 0, 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_directed_ops();
    test_warmup();
    test_ring_length_limits();
    test_sum_saturation();
    test_random_walk(10, 19);
    wait_drained();
    repeat (50) @(posedge clk);
    $display("sent %0d items over directed and random phases, checked %0d results",
             items_sent, results_seen);
    $display("covered writes, proposals, measurements, warm-up, ring limits and saturation");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[heisenberg_ring_metropolis] OK");
    end else begin
      $display("[heisenberg_ring_metropolis] ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("[heisenberg_ring_metropolis] ERROR");
    $finish;
  end

endmodule
